// ===== rtl/fprm_pkg.sv =====
// Shared types and constants for the frame peak / RMS meter.
// Used by fprm_root_unit, frame_peak_rms_meter, fprm_level_checker and frame_peak_rms_meter_test; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fprm_pkg;

   localparam int COUNT_WIDTH = 12;
   localparam int CNT_W       = COUNT_WIDTH;
   localparam int LEN_W       = 12;
   localparam int SMP_W       = 16;
   localparam int PROD_W      = 2 * SMP_W;
   localparam int SUM_W       = 42;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int UNIT_W      = ROOT_W + 2;
   localparam int STEP_W      = $clog2(SUM_W);
   localparam int CMP_W       = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

   localparam int SAMPLE_RATE = 44100;
   localparam int FRAME_RATE  = 25;
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(SAMPLE_RATE / FRAME_RATE);
   localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((1 << CNT_W) - 1);

   typedef enum logic [1:0] {
      T_IDLE,
      T_MUL,
      T_ACC,
      T_WAIT
   } fprm_top_state_type;

   typedef enum logic [1:0] {
      U_IDLE,
      U_DIV,
      U_SQRT,
      U_DONE
   } fprm_unit_state_type;

   typedef struct packed {
      logic             start;
      logic             ack;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] divisor;
   } fprm_unit_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SMP_W-1:0] rms;
   } fprm_unit_status_type;

endpackage

`default_nettype wire

// ===== rtl/fprm_root_unit.sv =====
// Mean-square divide and integer square root on one shared subtractor.
// Restoring divide (SUM_W steps), then digit-by-digit root (ROOT_W steps).
// Depends on fprm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fprm_root_unit
   import fprm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fprm_unit_ctrl_type   ctrl,
   output fprm_unit_status_type      status
);

   fprm_unit_state_type state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    work_ff, work_in;
   logic [UNIT_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]    div_ff, div_in;

   logic [UNIT_W-1:0]   op_a;
   logic [UNIT_W-1:0]   op_b;
   logic [UNIT_W:0]     diff;
   logic                borrow;

   assign diff   = {1'b0, op_a} - {1'b0, op_b};
   assign borrow = diff[UNIT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
   end

   always_comb begin
      op_a = {rem_ff[UNIT_W-2:0], work_ff[SUM_W-1]};
      op_b = UNIT_W'(div_ff);
      if (state_ff == U_SQRT) begin
         op_a = {rem_ff[UNIT_W-3:0], work_ff[SUM_W-1 -: 2]};
         op_b = {root_ff, 2'b01};
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      div_in   = div_ff;
      case (state_ff)
         U_IDLE: begin
            if (ctrl.start) begin
               work_in  = ctrl.sum;
               div_in   = ctrl.divisor;
               rem_in   = '0;
               step_in  = '0;
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            rem_in  = borrow ? op_a : diff[UNIT_W-1:0];
            work_in = {work_ff[SUM_W-2:0], ~borrow};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = U_SQRT;
            end
         end
         U_SQRT: begin
            rem_in  = borrow ? op_a : diff[UNIT_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], ~borrow};
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = U_DONE;
            end
         end
         U_DONE: begin
            if (ctrl.ack) begin
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   assign status.busy = (state_ff != U_IDLE);
   assign status.done = (state_ff == U_DONE);
   assign status.rms  = root_ff[SMP_W-1:0];

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_DIV) && (step_ff == STEP_W'(SUM_W - 1)) |=> (state_ff == U_SQRT))
      else $error("divide did not hand over to root");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_DIV) |-> (rem_ff < UNIT_W'(div_ff)) || (div_ff == '0))
      else $error("divide remainder not below divisor");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_SQRT) |-> (step_ff < STEP_W'(ROOT_W)))
      else $error("root step count overrun");

endmodule

`default_nettype wire

// ===== rtl/frame_peak_rms_meter.sv =====
// Frame peak and RMS level meter, top level.
// Depends on fprm_pkg and fprm_root_unit.
//
// Takes one signed 16-bit sample per req beat. An ordinary sample passes
// through accept, square on the 16x16 multiplier and accumulate. The sample
// that closes a frame also runs the shared subtractor through a 42-step
// restoring divide of the sum of squares by the sample count and a 21-step
// square root; req_stall stays high until both are done and the previous
// result is taken. One rsp beat per frame carries peak and RMS; it is
// held in an output register so the next frame accumulates while it waits.
`timescale 1ns / 1ps
`default_nettype none

module frame_peak_rms_meter
   import fprm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic signed [SMP_W-1:0] req_sample,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic [SMP_W-1:0] rsp_peak_level,
   output      logic [SMP_W-1:0] rsp_rms_level,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [LEN_W-1:0] csr_frame_length
);

   fprm_top_state_type   state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SMP_W-1:0]     peak_ff, peak_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SMP_W-1:0]     mag_ff, mag_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SMP_W-1:0]     hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]     rsp_peak_ff, rsp_peak_in;
   logic [SMP_W-1:0]     rsp_rms_ff, rsp_rms_in;

   fprm_unit_ctrl_type   unit_ctrl;
   fprm_unit_status_type unit_status;

   logic [SMP_W-1:0]     raw;
   logic [CMP_W-1:0]     len_ext;
   logic [CMP_W-1:0]     len_eff;
   logic [CMP_W-1:0]     taken;
   logic [SMP_W-1:0]     peak_new;
   logic [SUM_W-1:0]     sum_new;
   logic                 req_take;
   logic                 rsp_free;

   fprm_root_unit u_root (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (unit_ctrl),
      .status (unit_status)
   );

   assign raw      = req_sample;
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign len_ext  = CMP_W'(len_ff);
   assign taken    = CMP_W'(count_ff) + 1'b1;
   assign peak_new = (mag_ff > peak_ff) ? mag_ff : peak_ff;
   assign sum_new  = sum_ff + SUM_W'(prod_ff);

   always_comb begin
      len_eff = len_ext;
      if (len_ext > COUNT_MAX) begin
         len_eff = COUNT_MAX;
      end
      if (len_ext == '0) begin
         len_eff = CMP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         len_ff       <= LEN_RESET;
         count_ff     <= '0;
         peak_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      hold_ff     <= hold_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_rms_ff  <= rsp_rms_in;
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      peak_in      = peak_ff;
      sum_in       = sum_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_peak_in  = rsp_peak_ff;
      rsp_rms_in   = rsp_rms_ff;
      req_stall    = 1'b1;
      csr_ready    = 1'b0;
      unit_ctrl    = '{start: 1'b0, ack: 1'b0, sum: sum_new,
                       divisor: taken[CNT_W-1:0]};
      case (state_ff)
         T_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            if (csr_valid) begin
               len_in = csr_frame_length;
            end
            if (req_take) begin
               mag_in   = raw[SMP_W-1] ? SMP_W'(~raw + 1'b1) : raw;
               state_in = T_MUL;
            end
         end
         T_MUL: begin
            prod_in  = mag_ff * mag_ff;
            state_in = T_ACC;
         end
         T_ACC: begin
            if (taken < len_eff) begin
               count_in = taken[CNT_W-1:0];
               peak_in  = peak_new;
               sum_in   = sum_new;
               state_in = T_IDLE;
            end else begin
               unit_ctrl.start = 1'b1;
               hold_in  = peak_new;
               count_in = '0;
               peak_in  = '0;
               sum_in   = '0;
               state_in = T_WAIT;
            end
         end
         T_WAIT: begin
            if (unit_status.done && rsp_free) begin
               unit_ctrl.ack = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_peak_in   = hold_ff;
               rsp_rms_in    = unit_status.rms;
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_peak_level = rsp_peak_ff;
   assign rsp_rms_level  = rsp_rms_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff != CNT_W'(COUNT_MAX))
      else $error("sample count reached its limit");
   assert property (@(posedge clock) disable iff (reset)
      unit_ctrl.start |-> !unit_status.busy)
      else $error("root unit started while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rms_level <= rsp_peak_level))
      else $error("rms level above peak level");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_level <= 16'h8000))
      else $error("peak level out of range");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> (state_ff == T_MUL))
      else $error("accepted sample not squared");

endmodule

`default_nettype wire

// ===== tb/fprm_level_checker.sv =====
// Checker for frame_peak_rms_meter: watches req, rsp and csr beats, predicts peak/RMS levels.
// Depends on fprm_pkg for widths.
`timescale 1ns / 1ps

module fprm_level_checker
   import fprm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire logic [SMP_W-1:0] req_sample,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic [SMP_W-1:0] rsp_peak_level,
   input  wire logic [SMP_W-1:0] rsp_rms_level,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [LEN_W-1:0] csr_frame_length,
   output int                    mismatches,
   output int                    levels_owed
);

   typedef struct packed {
      logic [SMP_W-1:0] peak;
      logic [SMP_W-1:0] rms;
   } level_pair_type;

   level_pair_type   owed_levels[$];
   int               error_total = 0;
   logic [LEN_W-1:0] frame_len;
   logic [CNT_W-1:0] sample_cnt;
   logic [SMP_W-1:0] peak_mag;
   logic [SUM_W-1:0] square_acc;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_total++;
   endtask

   function automatic logic [SMP_W-1:0] floor_root(input logic [SUM_W-1:0] x);
      logic [ROOT_W-1:0] root;
      logic [ROOT_W-1:0] trial;
      root = '0;
      for (int i = ROOT_W - 1; i >= 0; i--) begin
         trial = root | (ROOT_W'(1) << i);
         if (64'(trial) * 64'(trial) <= 64'(x)) begin
            root = trial;
         end
      end
      return SMP_W'(root);
   endfunction

   task automatic accumulate_sample(input logic [SMP_W-1:0] raw);
      logic [SMP_W:0]   mag;
      logic [LEN_W-1:0] len;
      logic [CNT_W:0]   taken;
      level_pair_type   levels;
      mag = raw[SMP_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      if (mag[SMP_W-1:0] > peak_mag) begin
         peak_mag = mag[SMP_W-1:0];
      end
      square_acc = square_acc + SUM_W'(mag) * SUM_W'(mag);
      len = (frame_len == '0) ? LEN_W'(1) : frame_len;
      if (CMP_W'(len) > COUNT_MAX) begin
         len = LEN_W'(COUNT_MAX);
      end
      taken = {1'b0, sample_cnt} + 1'b1;
      if (taken < (CNT_W + 1)'(len)) begin
         sample_cnt = taken[CNT_W-1:0];
      end else begin
         levels.peak = peak_mag;
         levels.rms  = floor_root(square_acc / SUM_W'(taken));
         owed_levels.push_back(levels);
         sample_cnt = '0;
         peak_mag   = '0;
         square_acc = '0;
      end
   endtask

   always @(posedge clock) begin : watch
      level_pair_type want;
      if (reset) begin
         owed_levels.delete();
         frame_len  = LEN_RESET;
         sample_cnt = '0;
         peak_mag   = '0;
         square_acc = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            frame_len = csr_frame_length;
         end
         if (req_valid && !req_stall) begin
            accumulate_sample(req_sample);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_levels.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp beat peak %0d rms %0d",
                                         rsp_peak_level, rsp_rms_level));
            end else begin
               want = owed_levels.pop_front();
               if (rsp_peak_level !== want.peak) begin
                  report_mismatch($sformatf("peak_level got %0d expected %0d",
                                            rsp_peak_level, want.peak));
               end
               if (rsp_rms_level !== want.rms) begin
                  report_mismatch($sformatf("rms_level got %0d expected %0d",
                                            rsp_rms_level, want.rms));
               end
            end
         end
      end
      levels_owed <= owed_levels.size();
      mismatches  <= error_total;
   end

endmodule

// ===== tb/frame_peak_rms_meter_test.sv =====
// Testbench top for frame_peak_rms_meter: drives samples and frame lengths, gives the verdict.
// Depends on fprm_pkg, frame_peak_rms_meter and fprm_level_checker.
`timescale 1ns / 1ps

module frame_peak_rms_meter_test
   import fprm_pkg::*;
();

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 80;
   localparam int LEG_SAMPLES   = 110;
   localparam int LEAD_SAMPLES  = 400;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [SMP_W-1:0] req_sample;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [SMP_W-1:0] rsp_peak_level;
   logic [SMP_W-1:0] rsp_rms_level;
   logic             csr_valid;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_frame_length;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count   = 0;
   int mismatches;
   int levels_owed;

   frame_peak_rms_meter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_rms_level    (rsp_rms_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frame_length (csr_frame_length)
   );

   fprm_level_checker level_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_rms_level    (rsp_rms_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frame_length (csr_frame_length),
      .mismatches       (mismatches),
      .levels_owed      (levels_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   function automatic logic [SMP_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return SMP_W'($urandom_range(15)) ^ {SMP_W{$urandom_range(1) == 1}};
         default: return SMP_W'($urandom);
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(5))
         0: return LEN_W'(1);
         1: return LEN_W'(0);
         2: return LEN_W'($urandom_range(2, 4));
         3: return LEN_W'($urandom_range(5, 16));
         4: return LEN_W'($urandom_range(17, 40));
         default: return LEN_W'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic send_sample(input logic [SMP_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_frame_length(input logic [LEN_W-1:0] len);
      csr_valid        <= 1'b1;
      csr_frame_length <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drop valid, drain every owed rsp beat, then let the datapath go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (levels_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      csr_valid        = 1'b0;
      csr_frame_length = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // fill part of a full-scale frame at the reset length, then close it early
      repeat (LEAD_SAMPLES) send_sample(16'h8000);
      settle();
      write_frame_length(LEN_W'(3));
      send_sample(16'h8000);
      settle();

      write_frame_length(LEN_W'(1));
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      send_sample(16'h0001);
      send_sample(16'hFFFF);
      send_sample(16'h8001);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      settle();

      write_frame_length(LEN_W'(0));
      send_sample(16'h8000);
      send_sample(16'h1234);
      settle();

      write_frame_length(LEN_W'(2));
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0003);
      send_sample(16'h0004);
      settle();

      // lower the length while a frame is partly full
      write_frame_length(LEN_W'(10));
      repeat (6) send_sample(pick_sample());
      settle();
      write_frame_length(LEN_W'(3));
      send_sample(pick_sample());
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 78;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 78;
            end
            default: begin
               send_idle_pct = 13;
               rsp_stall_pct = 13;
            end
         endcase
         for (int leg = 0; leg < 3; leg++) begin
            settle();
            write_frame_length(pick_length());
            repeat (LEG_SAMPLES) send_sample(pick_sample());
         end
      end
      settle();

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
